>>> src/lppd_pkg.sv
// Shared types, codes and constants for the length-prefixed packet deframer.
`default_nettype none

package lppd_pkg;

    // Header layout: byte offsets within the 13-byte header.
    localparam int unsigned HDR_BYTES = 13;
    localparam logic [3:0] OFS_CLASS     = 4'd0;
    localparam logic [3:0] OFS_LEN_B0    = 4'd1;
    localparam logic [3:0] OFS_LEN_B1    = 4'd2;
    localparam logic [3:0] OFS_LEN_B2    = 4'd3;
    localparam logic [3:0] OFS_LEN_B3    = 4'd4;
    localparam logic [3:0] OFS_MSG       = 4'd5;
    localparam logic [3:0] OFS_RESERVED  = 4'd6;
    localparam logic [3:0] OFS_CHK_B0    = 4'd7;
    localparam logic [3:0] OFS_CHK_B1    = 4'd8;
    localparam logic [3:0] OFS_CHK_B2    = 4'd9;
    localparam logic [3:0] OFS_CHK_B3    = 4'd10;
    localparam logic [3:0] OFS_SEQ_B0    = 4'd11;
    localparam logic [3:0] OFS_SEQ_B1    = 4'd12;

    localparam logic [31:0] HDR_LEN_32   = 32'd13;
    localparam logic [7:0]  MSG_MASK     = 8'h1F;
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    // Depth of the descriptor queue between front and back.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // Result codes.
    localparam logic [1:0] STATUS_VALID     = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

    localparam logic [1:0] ROUTE_INTERNAL = 2'd0;
    localparam logic [1:0] ROUTE_CHANNEL  = 2'd1;
    localparam logic [1:0] ROUTE_GAME     = 2'd2;

    localparam logic [1:0] ACTION_ECHO_HEARTBEAT = 2'd0;
    localparam logic [1:0] ACTION_VERSION_REPLY  = 2'd1;
    localparam logic [1:0] ACTION_UNKNOWN_INT    = 2'd2;
    localparam logic [1:0] ACTION_FORWARD        = 2'd3;

    localparam logic [7:0] CLASS_INTERNAL = 8'd0;
    localparam logic [7:0] CLASS_CHANNEL  = 8'd1;
    localparam logic [4:0] MSG_HEARTBEAT  = 5'd0;
    localparam logic [4:0] MSG_VERSION    = 5'd1;

    // Header fields of one finished packet, as passed from front to back.
    typedef struct packed {
        logic [7:0]  class_code;
        logic [31:0] packet_length;
        logic [4:0]  message_number;
        logic [7:0]  reserved_byte;
        logic [31:0] checksum_word;
        logic [15:0] sequence_number;
    } desc_t;

    // Queue handshake seen from the front (push side).
    typedef struct packed {
        logic  push;
        desc_t data;
    } push_t;

    // Queue status seen from the back (pop side).
    typedef struct packed {
        logic  not_empty;
        desc_t data;
    } head_t;

endpackage

`default_nettype wire

>>> src/lppd_front.sv
// Front part: takes bytes, captures header fields and counts off each packet.
`default_nettype none

module lppd_front
    import lppd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        queue_full,
    output push_t            push_out
);

    logic [31:0] pos_reg,   pos_next;
    logic [7:0]  class_reg, class_next;
    logic [31:0] len_reg,   len_next;
    logic [4:0]  msg_reg,   msg_next;
    logic [7:0]  res_reg,   res_next;
    logic [31:0] chk_reg,   chk_next;
    logic [15:0] seq_reg,   seq_next;

    logic        accept;
    logic        in_header;
    logic        emit;
    logic [31:0] pos_inc;
    logic [7:0]  msg_byte;

    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;
    assign in_header = (pos_reg < HDR_LEN_32);
    assign pos_inc   = pos_reg + 32'd1;
    assign msg_byte  = s_data_byte & MSG_MASK;

    always_comb begin
        pos_next   = pos_reg;
        class_next = class_reg;
        len_next   = len_reg;
        msg_next   = msg_reg;
        res_next   = res_reg;
        chk_next   = chk_reg;
        seq_next   = seq_reg;
        emit       = 1'b0;

        if (accept) begin
            if (in_header) begin
                unique case (pos_reg[3:0])
                    OFS_CLASS:    class_next        = s_data_byte;
                    OFS_LEN_B0:   len_next[7:0]     = s_data_byte;
                    OFS_LEN_B1:   len_next[15:8]    = s_data_byte;
                    OFS_LEN_B2:   len_next[23:16]   = s_data_byte;
                    OFS_LEN_B3:   len_next[31:24]   = s_data_byte;
                    OFS_MSG:      msg_next          = msg_byte[4:0];
                    OFS_RESERVED: res_next          = s_data_byte;
                    OFS_CHK_B0:   chk_next[7:0]     = s_data_byte;
                    OFS_CHK_B1:   chk_next[15:8]    = s_data_byte;
                    OFS_CHK_B2:   chk_next[23:16]   = s_data_byte;
                    OFS_CHK_B3:   chk_next[31:24]   = s_data_byte;
                    OFS_SEQ_B0:   seq_next[7:0]     = s_data_byte;
                    OFS_SEQ_B1:   seq_next[15:8]    = s_data_byte;
                    default:      seq_next          = seq_reg;
                endcase

                if (pos_reg[3:0] == OFS_SEQ_B1) begin
                    // A length of at most the header size ends the packet here,
                    // which also covers lengths too short to be legal.
                    if (len_reg <= HDR_LEN_32) begin
                        emit     = 1'b1;
                        pos_next = '0;
                    end else begin
                        pos_next = HDR_LEN_32;
                    end
                end else begin
                    pos_next = pos_inc;
                end
            end else if (pos_inc >= len_reg) begin
                emit     = 1'b1;
                pos_next = '0;
            end else begin
                pos_next = pos_inc;
            end
        end
    end

    always_comb begin
        push_out.push                 = emit;
        push_out.data.class_code      = class_reg;
        push_out.data.packet_length   = len_reg;
        push_out.data.message_number  = msg_reg;
        push_out.data.reserved_byte   = res_reg;
        push_out.data.checksum_word   = chk_reg;
        // On the last header byte the upper sequence byte is still on the input.
        push_out.data.sequence_number = in_header ? {s_data_byte, seq_reg[7:0]} : seq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        class_reg <= class_next;
        len_reg   <= len_next;
        msg_reg   <= msg_next;
        res_reg   <= res_next;
        chk_reg   <= chk_next;
        seq_reg   <= seq_next;
    end

endmodule

`default_nettype wire

>>> src/lppd_queue.sv
// Short descriptor queue that decouples the front from the back.
`default_nettype none

module lppd_queue
    import lppd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push_in,
    output logic       full,
    input  wire logic  pop,
    output head_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic do_push;
    logic do_pop;

    assign full           = (count_reg == CNT_FULL);
    assign head.not_empty = (count_reg != '0);
    assign head.data      = entry_reg[rd_ptr_reg];

    // The front never pushes into a full queue; the back never pops an empty one.
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && head.not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_in.data;
        end
    end

endmodule

`default_nettype wire

>>> src/lppd_back.sv
// Back part: grades each descriptor, keeps the valid count and drives the result.
`default_nettype none

module lppd_back
    import lppd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire head_t       head,
    output logic             pop,
    input  wire logic [15:0] max_len,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_route,
    output logic [1:0]       m_action,
    output logic [7:0]       m_class_code,
    output logic [4:0]       m_message_number,
    output logic [7:0]       m_reserved_byte,
    output logic [31:0]      m_packet_length,
    output logic [31:0]      m_checksum_word,
    output logic [15:0]      m_sequence_number,
    output logic [31:0]      m_valid_packet_total
);

    logic        out_valid_reg, out_valid_next;
    logic [31:0] total_reg,     total_next;
    logic [1:0]  status_reg,    status_next;
    logic [1:0]  route_reg,     route_next;
    logic [1:0]  action_reg,    action_next;
    desc_t       desc_reg;

    assign pop = head.not_empty && (!out_valid_reg || m_ready);

    always_comb begin
        route_next  = ROUTE_INTERNAL;
        action_next = ACTION_ECHO_HEARTBEAT;
        total_next  = total_reg;

        if (head.data.packet_length < HDR_LEN_32) begin
            status_next = STATUS_TOO_SHORT;
        end else if (head.data.packet_length > {16'd0, max_len}) begin
            status_next = STATUS_TOO_LONG;
        end else begin
            status_next = STATUS_VALID;
        end

        // Route and action are only graded for valid packets.
        if (status_next == STATUS_VALID) begin
            total_next = total_reg + 32'd1;
            priority if (head.data.class_code == CLASS_INTERNAL) begin
                route_next = ROUTE_INTERNAL;
                priority if (head.data.message_number == MSG_HEARTBEAT) begin
                    action_next = ACTION_ECHO_HEARTBEAT;
                end else if (head.data.message_number == MSG_VERSION) begin
                    action_next = ACTION_VERSION_REPLY;
                end else begin
                    action_next = ACTION_UNKNOWN_INT;
                end
            end else if (head.data.class_code == CLASS_CHANNEL) begin
                route_next  = ROUTE_CHANNEL;
                action_next = ACTION_FORWARD;
            end else begin
                route_next  = ROUTE_GAME;
                action_next = ACTION_FORWARD;
            end
        end

        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            route_reg  <= route_next;
            action_reg <= action_next;
            desc_reg   <= head.data;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_status             = status_reg;
    assign m_route              = route_reg;
    assign m_action             = action_reg;
    assign m_class_code         = desc_reg.class_code;
    assign m_message_number     = desc_reg.message_number;
    assign m_reserved_byte      = desc_reg.reserved_byte;
    assign m_packet_length      = desc_reg.packet_length;
    assign m_checksum_word      = desc_reg.checksum_word;
    assign m_sequence_number    = desc_reg.sequence_number;
    assign m_valid_packet_total = total_reg;

endmodule

`default_nettype wire

>>> src/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer.
//
//   Channel  Direction  Transfer                 Payload
//   s_       in         one stream byte          s_data_byte
//   m_       out        one packet descriptor    status, route, action, header fields,
//                                                valid_packet_total
//   cfg_     in         max_packet_len write     cfg_data
//
// One byte is taken in every cycle while the queue is not full. A descriptor is
// registered into the descriptor queue with the transfer of the packet's last byte and
// moves into the output register once that register is empty or m_ready is high.
// Reset is synchronous and active low; there is no clearing pass after it.
// When m_ stalls, up to QUEUE_DEPTH descriptors wait in the queue besides the output
// register; s_ready falls only once the queue is full (QUEUE_DEPTH from 2 to 32).
`default_nettype none

module length_prefixed_packet_deframer
    import lppd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_route,
    output logic [1:0]       m_action,
    output logic [7:0]       m_class_code,
    output logic [4:0]       m_message_number,
    output logic [7:0]       m_reserved_byte,
    output logic [31:0]      m_packet_length,
    output logic [31:0]      m_checksum_word,
    output logic [15:0]      m_sequence_number,
    output logic [31:0]      m_valid_packet_total,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] max_len_reg;
    push_t       push;
    head_t       head;
    logic        queue_full;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    lppd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .queue_full  (queue_full),
        .push_out    (push)
    );

    lppd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push),
        .full    (queue_full),
        .pop     (pop),
        .head    (head)
    );

    lppd_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .head                 (head),
        .pop                  (pop),
        .max_len              (max_len_reg),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_route              (m_route),
        .m_action             (m_action),
        .m_class_code         (m_class_code),
        .m_message_number     (m_message_number),
        .m_reserved_byte      (m_reserved_byte),
        .m_packet_length      (m_packet_length),
        .m_checksum_word      (m_checksum_word),
        .m_sequence_number    (m_sequence_number),
        .m_valid_packet_total (m_valid_packet_total)
    );

endmodule

`default_nettype wire
